FILE: sv/sorted_page_table_top_assert.svh
// Assertion macros for the sorted page table.
// Used by sorted_page_table_top; no other dependencies.
`ifndef SORTED_PAGE_TABLE_TOP_ASSERT_SVH
`define SORTED_PAGE_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SPT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("spt check failed");
`define SPT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("spt never failed");
`else
`define SPT_ASSERT(lbl, clk, rst_n, prop)
`define SPT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: sv/spt_pkg.sv
// Shared types and constants for the sorted page table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spt_pkg;
  localparam int MAX_RESULTS = 32;
  localparam int FIELD_W = 32;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DUP = 3'd1, ST_NOTFOUND = 3'd2,
    ST_FULL = 3'd3, ST_FEW = 3'd4, ST_EMPTY = 3'd5
  } st_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0, OP_FIND = 2'd1, OP_SPLIT = 2'd2, OP_MIN = 2'd3
  } op_t;

  typedef struct packed {
    logic latch_in;
    logic idx_inc;
    logic idx_dec;
    logic idx_ld_cnt;
    logic idx_ld_sel;
    logic idx_ld_mid;
    logic pos_ld_hit;
    logic pos_ld_end;
    logic rd_idx;
    logic rd_idx_m1;
    logic wr_shift;
    logic wr_new;
    logic cnt_inc;
    logic cnt_mid;
    logic emit;
    st_t  emit_st;
    logic emit_page;
    logic emit_key;
    logic emit_offs;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic idx_at_cnt;
    logic idx_at_pos;
    logic idx_at_end;
    logic cnt_zero;
    logic cnt_lt2;
    logic cnt_full;
    logic ge;
    logic eq;
    logic eq_r;
    logic leaf;
    logic out_free;
  } stat_t;
endpackage
`default_nettype wire

FILE: sv/spt_in_if.sv
// Input item channel of the sorted page table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface spt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] key;
  logic [31:0] child_page;
  logic [31:0] entry_offs;
  modport source (output valid, kind, key, child_page, entry_offs, input ready);
  modport sink (input valid, kind, key, child_page, entry_offs, output ready);
endinterface
`default_nettype wire

FILE: sv/spt_out_if.sv
// Result item channel of the sorted page table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface spt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] found_page;
  logic [31:0] out_key;
  logic [31:0] out_offset;
  logic        last;
  modport source (output valid, status, found_page, out_key, out_offset, last, input ready);
  modport sink (input valid, status, found_page, out_key, out_offset, last, output ready);
endinterface
`default_nettype wire

FILE: sv/spt_ctrl.sv
// Controller state machine of the sorted page table.
// Depends on spt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_kind,
  output logic               in_ready,
  input  spt_pkg::stat_t     stat,
  output spt_pkg::cmd_t      cmd
);
  import spt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_SCMP, S_ROUTE, S_SH_CHK, S_SH_WR,
    S_FRD, S_RESULT, S_SP_RD, S_SP_EMIT
  } state_t;

  state_t state_r, state_nxt;
  op_t    kind_r, kind_nxt;
  st_t    res_st_r, res_st_nxt;
  logic   res_page_r, res_page_nxt;
  logic   res_key_r, res_key_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.emit_st  = ST_OK;
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    res_st_nxt   = res_st_r;
    res_page_nxt = res_page_r;
    res_key_nxt  = res_key_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          kind_nxt     = op_t'(in_kind);
          res_st_nxt   = ST_OK;
          res_page_nxt = 1'b0;
          res_key_nxt  = 1'b0;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (kind_r)
          OP_INSERT: state_nxt = S_SCAN;
          OP_FIND: begin
            if (stat.cnt_zero) begin
              res_st_nxt = ST_NOTFOUND;
              state_nxt  = S_RESULT;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          OP_SPLIT: begin
            if (stat.cnt_lt2) begin
              res_st_nxt = ST_FEW;
              state_nxt  = S_RESULT;
            end else begin
              cmd.idx_ld_mid = 1'b1;
              state_nxt      = S_SP_RD;
            end
          end
          OP_MIN: begin
            if (stat.cnt_zero) begin
              res_st_nxt = ST_EMPTY;
            end else begin
              cmd.rd_idx  = 1'b1;
              res_key_nxt = 1'b1;
            end
            state_nxt = S_RESULT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (stat.idx_at_cnt) begin
          cmd.pos_ld_end = 1'b1;
          state_nxt      = S_ROUTE;
        end else begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_SCMP;
        end
      end
      S_SCMP: begin
        if (stat.ge) begin
          cmd.pos_ld_hit = 1'b1;
          state_nxt      = S_ROUTE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_ROUTE: begin
        if (kind_r == OP_INSERT) begin
          if (stat.eq_r) begin
            res_st_nxt = ST_DUP;
            state_nxt  = S_RESULT;
          end else if (stat.cnt_full) begin
            res_st_nxt = ST_FULL;
            state_nxt  = S_RESULT;
          end else begin
            cmd.idx_ld_cnt = 1'b1;
            state_nxt      = S_SH_CHK;
          end
        end else if (stat.leaf && !stat.eq_r) begin
          res_st_nxt = ST_NOTFOUND;
          state_nxt  = S_RESULT;
        end else begin
          cmd.idx_ld_sel = 1'b1;
          state_nxt      = S_FRD;
        end
      end
      S_SH_CHK: begin
        if (stat.idx_at_pos) begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_RESULT;
        end else begin
          cmd.rd_idx_m1 = 1'b1;
          state_nxt     = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_nxt    = S_SH_CHK;
      end
      S_FRD: begin
        cmd.rd_idx   = 1'b1;
        res_page_nxt = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_st   = res_st_r;
          cmd.emit_page = res_page_r;
          cmd.emit_key  = res_key_r;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SP_RD: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = S_SP_EMIT;
      end
      S_SP_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_page = 1'b1;
          cmd.emit_key  = 1'b1;
          cmd.emit_offs = 1'b1;
          cmd.emit_last = stat.idx_at_end;
          if (stat.idx_at_end) begin
            cmd.cnt_mid = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_SP_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      kind_r     <= OP_INSERT;
      res_st_r   <= ST_OK;
      res_page_r <= 1'b0;
      res_key_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      kind_r     <= kind_nxt;
      res_st_r   <= res_st_nxt;
      res_page_r <= res_page_nxt;
      res_key_r  <= res_key_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: sv/spt_dp.sv
// Datapath of the sorted page table: entry memories, index, count, result register.
// Depends on spt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spt_dp #(
  parameter int PAGE_CAPACITY = 64,
  parameter int KEY_BITS      = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic [31:0]        in_key,
  input  wire logic [31:0]        in_child,
  input  wire logic [31:0]        in_offs,
  input  spt_pkg::cmd_t           cmd,
  output spt_pkg::stat_t          stat,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [31:0]             out_page,
  output logic [31:0]             out_key,
  output logic [31:0]             out_offs,
  output logic                    out_last
);
  import spt_pkg::*;

  localparam int CW = $clog2(PAGE_CAPACITY + 1);
  localparam int AW = $clog2(PAGE_CAPACITY);
  localparam int SK = (KEY_BITS < 32) ? KEY_BITS : 32;

  logic [SK-1:0] mem_key  [PAGE_CAPACITY];
  logic [31:0]   mem_page [PAGE_CAPACITY];
  logic [31:0]   mem_offs [PAGE_CAPACITY];

  logic [CW-1:0] cnt_r, idx_r, pos_r, sel, mid, span, end_idx;
  logic          eq_r, leaf_r, out_valid_r;
  logic [SK-1:0] key_r, rk_r;
  logic [31:0]   child_r, offs_r, rp_r, ro_r;
  logic [AW-1:0] rd_addr, wr_addr;

  assign mid  = cnt_r >> 1;
  assign span = cnt_r - mid;
  always_comb begin
    if (32'(span) > MAX_RESULTS) end_idx = mid + CW'(MAX_RESULTS);
    else end_idx = mid + span;
  end

  always_comb begin
    if (leaf_r) sel = pos_r;
    else if (pos_r == cnt_r || (!eq_r && pos_r != '0)) sel = pos_r - CW'(1);
    else sel = pos_r;
  end

  assign rd_addr = cmd.rd_idx_m1 ? AW'(idx_r - CW'(1)) : idx_r[AW-1:0];
  assign wr_addr = cmd.wr_new ? pos_r[AW-1:0] : idx_r[AW-1:0];

  assign stat.idx_at_cnt = (idx_r == cnt_r);
  assign stat.idx_at_pos = (idx_r == pos_r);
  assign stat.idx_at_end = (CW'(idx_r + CW'(1)) == end_idx);
  assign stat.cnt_zero   = (cnt_r == '0);
  assign stat.cnt_lt2    = (cnt_r < CW'(2));
  assign stat.cnt_full   = (cnt_r == CW'(PAGE_CAPACITY));
  assign stat.ge         = (rk_r >= key_r);
  assign stat.eq         = (rk_r == key_r);
  assign stat.eq_r       = eq_r;
  assign stat.leaf       = leaf_r;
  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      leaf_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) leaf_r <= cfg_wdata;
      if (cmd.cnt_inc) cnt_r <= cnt_r + CW'(1);
      else if (cmd.cnt_mid) cnt_r <= mid;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      key_r   <= in_key[SK-1:0];
      child_r <= in_child;
      offs_r  <= in_offs;
      idx_r   <= '0;
    end else if (cmd.idx_inc) idx_r <= idx_r + CW'(1);
    else if (cmd.idx_dec) idx_r <= idx_r - CW'(1);
    else if (cmd.idx_ld_cnt) idx_r <= cnt_r;
    else if (cmd.idx_ld_sel) idx_r <= sel;
    else if (cmd.idx_ld_mid) idx_r <= mid;
    if (cmd.pos_ld_hit) begin
      pos_r <= idx_r;
      eq_r  <= stat.eq;
    end else if (cmd.pos_ld_end) begin
      pos_r <= idx_r;
      eq_r  <= 1'b0;
    end
    if (cmd.rd_idx || cmd.rd_idx_m1) begin
      rk_r <= mem_key[rd_addr];
      rp_r <= mem_page[rd_addr];
      ro_r <= mem_offs[rd_addr];
    end
    if (cmd.wr_new) begin
      mem_key[wr_addr]  <= key_r;
      mem_page[wr_addr] <= child_r;
      mem_offs[wr_addr] <= offs_r;
    end else if (cmd.wr_shift) begin
      mem_key[wr_addr]  <= rk_r;
      mem_page[wr_addr] <= rp_r;
      mem_offs[wr_addr] <= ro_r;
    end
    if (cmd.emit) begin
      out_status <= cmd.emit_st;
      out_page   <= cmd.emit_page ? rp_r : '0;
      out_key    <= cmd.emit_key ? 32'(rk_r) : '0;
      out_offs   <= cmd.emit_offs ? ro_r : '0;
      out_last   <= cmd.emit_last;
    end
  end
endmodule
`default_nettype wire

FILE: sv/sorted_page_table_top.sv
// Sorted page table: one B-tree page of key-sorted entries.
// Channels: in_chan (sink) takes items of kind insert, find, split or min-key;
// out_chan (source) returns result items, last marks the final one of an item.
// cfg_we/cfg_wdata set the leaf_page register (1 leaf exact match, 0 internal floor).
// One item is processed at a time; the memory has one read and one write port.
// Insert: the controller scans for the sorted place p, then shifts the entries from p
// upward; no shift is needed when the key is above every entry.
// Find: a scan, then a read of the selected entry; a leaf miss skips the read.
// Split: one result item per emitted entry; fewer than two entries, duplicate,
// full or empty give one item.
// The result register frees the input side: a new item is taken while a
// result still waits. A stalled receiver holds the current result and stops
// the controller at the next emit.
// Reset empties the page (count 0) and sets leaf_page to 1; entry memories
// are not cleared since entries at or above the count are never read.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_page_table_top_assert.svh"
module sorted_page_table_top #(
  parameter int PAGE_CAPACITY = 64,
  parameter int KEY_BITS      = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spt_in_if.sink    in_chan,
  spt_out_if.source out_chan,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);
  import spt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  spt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_kind  (in_chan.kind),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spt_dp #(
    .PAGE_CAPACITY (PAGE_CAPACITY),
    .KEY_BITS      (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_key     (in_chan.key),
    .in_child   (in_chan.child_page),
    .in_offs    (in_chan.entry_offs),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_status (out_chan.status),
    .out_page   (out_chan.found_page),
    .out_key    (out_chan.out_key),
    .out_offs   (out_chan.out_offset),
    .out_last   (out_chan.last)
  );

  `SPT_ASSERT(a_emit_free, clk, rst_n, cmd.emit |-> stat.out_free)
  `SPT_NEVER(a_no_ins_full, clk, rst_n, cmd.wr_new && stat.cnt_full)
  `SPT_NEVER(a_one_write, clk, rst_n, cmd.wr_new && cmd.wr_shift)
  `SPT_ASSERT(a_one_item, clk, rst_n, (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
endmodule
`default_nettype wire

FILE: test/sorted_page_table_top_tb.sv
// Testbench for sorted_page_table_top: directed table, then random B-tree page traffic.
// Depends on spt_pkg, spt_in_if, spt_out_if and the RTL; results checked against a predictor.
`timescale 1ns / 1ps
module sorted_page_table_top_tb;
  import spt_pkg::*;

  localparam int CAP = 64;
  localparam int LIMIT = 400000;

  typedef struct {
    st_t         status;
    logic [31:0] page;
    logic [31:0] key;
    logic [31:0] offs;
    logic        last;
  } page_res_t;

  typedef struct {
    op_t         op;
    logic [31:0] key;
    logic [31:0] child;
    logic [31:0] offs;
    logic        has_exp;
    st_t         exp_st;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  spt_in_if in_chan();
  spt_out_if out_chan();

  sorted_page_table_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [31:0] pg_keys[CAP];
  logic [31:0] pg_pages[CAP];
  logic [31:0] pg_offs[CAP];
  int          pg_count;
  logic        pg_leaf;

  page_res_t pending_results[$];
  int        mismatches;
  int        cycles = 0;
  bit        failed;
  bit        sink_calm;
  int        hold_off;

  function automatic page_res_t mk(st_t s, logic [31:0] p, logic [31:0] k,
                                   logic [31:0] o, logic l);
    page_res_t r;
    r.status = s; r.page = p; r.key = k; r.offs = o; r.last = l;
    return r;
  endfunction

  function automatic int first_not_below(logic [31:0] k);
    int i;
    i = 0;
    while (i < pg_count && pg_keys[i] < k) i++;
    return i;
  endfunction

  task automatic apply_page_op(op_t op, logic [31:0] k, logic [31:0] ch, logic [31:0] of);
    int p;
    int mid;
    int n;
    case (op)
      OP_INSERT: begin
        p = first_not_below(k);
        if (p < pg_count && pg_keys[p] == k) begin
          pending_results.push_back(mk(ST_DUP, 0, 0, 0, 1));
        end else if (pg_count >= CAP) begin
          pending_results.push_back(mk(ST_FULL, 0, 0, 0, 1));
        end else begin
          for (int i = pg_count; i > p; i--) begin
            pg_keys[i] = pg_keys[i-1]; pg_pages[i] = pg_pages[i-1]; pg_offs[i] = pg_offs[i-1];
          end
          pg_keys[p] = k; pg_pages[p] = ch; pg_offs[p] = of;
          pg_count++;
          pending_results.push_back(mk(ST_OK, 0, 0, 0, 1));
        end
      end
      OP_FIND: begin
        if (pg_count == 0) begin
          pending_results.push_back(mk(ST_NOTFOUND, 0, 0, 0, 1));
        end else begin
          p = first_not_below(k);
          if (pg_leaf) begin
            if (p < pg_count && pg_keys[p] == k)
              pending_results.push_back(mk(ST_OK, pg_pages[p], 0, 0, 1));
            else
              pending_results.push_back(mk(ST_NOTFOUND, 0, 0, 0, 1));
          end else begin
            if (p >= pg_count) p = pg_count - 1;
            else if (pg_keys[p] > k && p != 0) p--;
            pending_results.push_back(mk(ST_OK, pg_pages[p], 0, 0, 1));
          end
        end
      end
      OP_SPLIT: begin
        if (pg_count < 2) begin
          pending_results.push_back(mk(ST_FEW, 0, 0, 0, 1));
        end else begin
          mid = pg_count / 2;
          n = pg_count - mid;
          if (n > MAX_RESULTS) n = MAX_RESULTS;
          for (int i = 0; i < n; i++)
            pending_results.push_back(mk(ST_OK, pg_pages[mid+i], pg_keys[mid+i],
                                         pg_offs[mid+i], i + 1 == n));
          pg_count = mid;
        end
      end
      default: begin
        if (pg_count == 0) pending_results.push_back(mk(ST_EMPTY, 0, 0, 0, 1));
        else pending_results.push_back(mk(ST_OK, 0, pg_keys[0], 0, 1));
      end
    endcase
  endtask

  task automatic send_item(op_t op, logic [31:0] k, logic [31:0] ch, logic [31:0] of,
                           bit gaps);
    while (gaps && $urandom_range(99) < 13) @(posedge clk);
    in_chan.valid <= 1'b1;
    in_chan.kind <= op;
    in_chan.key <= k;
    in_chan.child_page <= ch;
    in_chan.entry_offs <= of;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    apply_page_op(op, k, ch, of);
    in_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_leaf(logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pg_leaf = v;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_key();
    case ($urandom_range(3))
      0: return $urandom_range(40);
      1: return 32'hFFFF_FFFF - $urandom_range(40);
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= sink_calm || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    page_res_t e;
    cycles <= cycles + 1;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        failed = 1'b1;
        if (mismatches < 10) $display("unexpected result item status=%0d", out_chan.status);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (out_chan.status !== e.status || out_chan.found_page !== e.page ||
            out_chan.out_key !== e.key || out_chan.out_offset !== e.offs ||
            out_chan.last !== e.last) begin
          failed = 1'b1;
          if (mismatches < 10)
            $display("mismatch: exp st=%0d pg=%h key=%h off=%h last=%b got st=%0d pg=%h key=%h off=%h last=%b",
                     e.status, e.page, e.key, e.offs, e.last, out_chan.status,
                     out_chan.found_page, out_chan.out_key, out_chan.out_offset, out_chan.last);
          mismatches++;
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  stim_row_t dir_rows[$];

  task automatic add_row(op_t op, logic [31:0] k, logic [31:0] ch, logic [31:0] of,
                         bit he, st_t s);
    stim_row_t r;
    r.op = op; r.key = k; r.child = ch; r.offs = of; r.has_exp = he; r.exp_st = s;
    dir_rows.push_back(r);
  endtask

  initial begin
    int n;
    logic [31:0] k;
    logic [31:0] used_keys[$];
    in_chan.valid = 1'b0;
    in_chan.kind = OP_INSERT;
    in_chan.key = '0;
    in_chan.child_page = '0;
    in_chan.entry_offs = '0;
    out_chan.ready = 1'b0;
    mismatches = 0;
    failed = 1'b0;
    sink_calm = 1'b0;
    hold_off = 0;
    pg_count = 0;
    pg_leaf = 1'b1;

    add_row(OP_FIND, 32'h5, 0, 0, 1, ST_NOTFOUND);
    add_row(OP_MIN, 0, 0, 0, 1, ST_EMPTY);
    add_row(OP_SPLIT, 0, 0, 0, 1, ST_FEW);
    add_row(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h0, 1, ST_OK);
    add_row(OP_SPLIT, 0, 0, 0, 1, ST_FEW);
    add_row(OP_INSERT, 32'h0, 32'h1, 32'h1, 1, ST_DUP);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1, ST_OK);
    add_row(OP_INSERT, 32'h8000_0000, 32'hAAAA_5555, 32'h5555_AAAA, 1, ST_OK);
    add_row(OP_INSERT, 32'h100, 32'h1234, 32'h4321, 1, ST_OK);
    add_row(OP_FIND, 32'h100, 0, 0, 0, ST_OK);
    add_row(OP_FIND, 32'h101, 0, 0, 1, ST_NOTFOUND);
    add_row(OP_FIND, 32'hFFFF_FFFF, 0, 0, 0, ST_OK);
    add_row(OP_MIN, 0, 0, 0, 0, ST_OK);
    add_row(OP_SPLIT, 0, 0, 0, 0, ST_OK);
    add_row(OP_MIN, 0, 0, 0, 0, ST_OK);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].child, dir_rows[i].offs, 1);
      if (dir_rows[i].has_exp && pending_results[$].status !== dir_rows[i].exp_st) begin
        failed = 1'b1;
        $display("directed row %0d: predictor status %0d, table %0d", i,
                 pending_results[$].status, dir_rows[i].exp_st);
      end
    end

    // fill to capacity, overflow, then internal routing
    drain();
    sink_calm = 1'b1;
    hold_off = 300;
    while (pg_count < CAP) send_item(OP_INSERT, $urandom(), $urandom(), $urandom(), 0);
    send_item(OP_INSERT, 32'h7777_7777, 1, 1, 0);
    sink_calm = 1'b0;
    write_leaf(1'b0);
    send_item(OP_FIND, 32'h0, 0, 0, 1);
    send_item(OP_FIND, 32'hFFFF_FFFF, 0, 0, 1);
    send_item(OP_FIND, pg_keys[5], 0, 0, 1);
    send_item(OP_FIND, pg_keys[5] + 1, 0, 0, 1);
    send_item(OP_SPLIT, 0, 0, 0, 1);
    send_item(OP_SPLIT, 0, 0, 0, 1);

    for (int ph = 0; ph < 4; ph++) begin
      write_leaf(ph[0]);
      used_keys.delete();
      for (int j = 0; j < 9; j++) begin
        n = $urandom_range(99);
        if (n < 45) begin
          k = rand_key();
          used_keys.push_back(k);
          send_item(OP_INSERT, k, $urandom(), $urandom(), 1);
        end else if (n < 80) begin
          if (used_keys.size() != 0 && $urandom_range(1))
            k = used_keys[$urandom_range(used_keys.size() - 1)] + $urandom_range(1);
          else
            k = rand_key();
          send_item(OP_FIND, k, 0, 0, 1);
        end else if (n < 90) begin
          send_item(OP_MIN, $urandom(), $urandom(), $urandom(), 1);
        end else begin
          send_item(OP_SPLIT, $urandom(), $urandom(), $urandom(), 1);
        end
      end
    end
    write_leaf(1'b1);
    drain();

    if (!failed && mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
